// File: rtl/ibpg_pkg.sv
package ibpg_pkg;

  // defaults for the top level parameters
  localparam int DEF_MAX_CELLS   = 4096;
  localparam int DEF_DATA_BITS   = 32;
  localparam int DEF_PARITY_BITS = 16;

  // operation codes of an input transfer
  localparam logic [1:0] OP_LOAD_DATA   = 2'd0;
  localparam logic [1:0] OP_LOAD_PARITY = 2'd1;
  localparam logic [1:0] OP_RENDER      = 2'd2;
  localparam logic [1:0] OP_RSVD        = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_FRAME  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ILEAVE_IDX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_FRAME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_FRAMES = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PROJ_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ILEAVE_W    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ILEAVE_H    = 3'd7;
  localparam int CFG_DATA_W = 13;

  // configuration reset values
  localparam logic [5:0]  RST_DATA_FRAMES = 6'd16;
  localparam logic [12:0] RST_PROJ_WIDTH  = 13'd1024;
  localparam logic [4:0]  RST_ILEAVE_W    = 5'd4;
  localparam logic [4:0]  RST_ILEAVE_H    = 5'd4;

  // luminance levels
  localparam logic [7:0] LUM_ON  = 8'd255;
  localparam logic [7:0] LUM_OFF = 8'd0;

  // width of a computed cell number: 12 bit column + 12 x 13 bit product
  localparam int CNUM_W = 26;

  // ceil(2^24 / d) for a cell size d, zero treated as one; exact for 13 bit dividends
  localparam int RECIP_SHIFT = 24;

  function automatic logic [24:0] recip(input logic [4:0] d);
    logic [24:0] r;
    unique case (d)
      5'd0:  r = 25'd16777216;
      5'd1:  r = 25'd16777216;
      5'd2:  r = 25'd8388608;
      5'd3:  r = 25'd5592406;
      5'd4:  r = 25'd4194304;
      5'd5:  r = 25'd3355444;
      5'd6:  r = 25'd2796203;
      5'd7:  r = 25'd2396746;
      5'd8:  r = 25'd2097152;
      5'd9:  r = 25'd1864136;
      5'd10: r = 25'd1677722;
      5'd11: r = 25'd1525202;
      5'd12: r = 25'd1398102;
      5'd13: r = 25'd1290556;
      5'd14: r = 25'd1198373;
      5'd15: r = 25'd1118482;
      5'd16: r = 25'd1048576;
      5'd17: r = 25'd986896;
      5'd18: r = 25'd932068;
      5'd19: r = 25'd883012;
      5'd20: r = 25'd838861;
      5'd21: r = 25'd798916;
      5'd22: r = 25'd762601;
      5'd23: r = 25'd729445;
      5'd24: r = 25'd699051;
      5'd25: r = 25'd671089;
      5'd26: r = 25'd645278;
      5'd27: r = 25'd621379;
      5'd28: r = 25'd599187;
      5'd29: r = 25'd578525;
      5'd30: r = 25'd559241;
      5'd31: r = 25'd541201;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] cell_index;
    logic [31:0] cell_word;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic        mask_bit;
  } in_item_t;

  typedef struct packed {
    logic [7:0] luminance;
    logic       in_active_offset;
  } out_item_t;

  // quotient by reciprocal multiply
  function automatic logic [12:0] div_q(input logic [12:0] n, input logic [24:0] r);
    logic [37:0] p;
    p = 38'(n) * 38'(r);
    return p[RECIP_SHIFT+12:RECIP_SHIFT];
  endfunction

endpackage

// File: rtl/ibpg_cell_mem.sv
module ibpg_cell_mem #(
  parameter int DEPTH  = ibpg_pkg::DEF_MAX_CELLS,
  parameter int DATA_W = ibpg_pkg::DEF_DATA_BITS,
  parameter int PAR_W  = ibpg_pkg::DEF_PARITY_BITS,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we_data,
  input  logic              we_par,
  input  logic              re,
  input  logic [AW-1:0]     addr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [PAR_W-1:0]  wpar,
  output logic [DATA_W-1:0] rd_data,
  output logic [PAR_W-1:0]  rd_par
);

  logic [DATA_W-1:0] data_mem [DEPTH];
  logic [PAR_W-1:0]  par_mem  [DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic [PAR_W-1:0]  rd_par_r;

  // data words
  always_ff @(posedge clk) begin
    if (we_data) begin
      data_mem[addr] <= wdata;
    end
    if (re) begin
      rd_data_r <= data_mem[addr];
    end
  end

  // parity words
  always_ff @(posedge clk) begin
    if (we_par) begin
      par_mem[addr] <= wpar;
    end
    if (re) begin
      rd_par_r <= par_mem[addr];
    end
  end

  assign rd_data = rd_data_r;
  assign rd_par  = rd_par_r;

endmodule

// File: rtl/interleaved_bitplane_pattern_gen.sv
// channel   direction  handshake           payload
// in_       input      in_valid/in_ready    ibpg_pkg::in_item_t  (load or render)
// out_      output     out_valid/out_ready  ibpg_pkg::out_item_t (render only)
// cfg_      input      cfg_we               cfg_index, cfg_data
//
// One item per clock while the output is not held; a render result passes
// three arithmetic stages and one cell memory read, then the output register.
// Loads write the cell memory from the third stage and give no result.
// Reset is synchronous and clears the pipeline and the configuration only.
// Stages advance independently, so bubbles close up while out_ready is low.
module interleaved_bitplane_pattern_gen #(
  parameter int MAX_CELLS   = ibpg_pkg::DEF_MAX_CELLS,
  parameter int DATA_BITS   = ibpg_pkg::DEF_DATA_BITS,
  parameter int PARITY_BITS = ibpg_pkg::DEF_PARITY_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ibpg_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ibpg_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [ibpg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ibpg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CELL_AW = $clog2(MAX_CELLS);

  // configuration registers
  logic        mode_r;
  logic [5:0]  scan_frame_r;
  logic [7:0]  ileave_idx_r;
  logic [8:0]  cal_frame_r;
  logic [5:0]  data_frames_r;
  logic [12:0] proj_width_r;
  logic [4:0]  ileave_w_r;
  logic [4:0]  ileave_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= 1'b0;
      scan_frame_r  <= 6'd0;
      ileave_idx_r  <= 8'd0;
      cal_frame_r   <= 9'd0;
      data_frames_r <= ibpg_pkg::RST_DATA_FRAMES;
      proj_width_r  <= ibpg_pkg::RST_PROJ_WIDTH;
      ileave_w_r    <= ibpg_pkg::RST_ILEAVE_W;
      ileave_h_r    <= ibpg_pkg::RST_ILEAVE_H;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ibpg_pkg::CFG_MODE:        mode_r        <= cfg_data[0];
        ibpg_pkg::CFG_SCAN_FRAME:  scan_frame_r  <= cfg_data[5:0];
        ibpg_pkg::CFG_ILEAVE_IDX:  ileave_idx_r  <= cfg_data[7:0];
        ibpg_pkg::CFG_CAL_FRAME:   cal_frame_r   <= cfg_data[8:0];
        ibpg_pkg::CFG_DATA_FRAMES: data_frames_r <= cfg_data[5:0];
        ibpg_pkg::CFG_PROJ_WIDTH:  proj_width_r  <= cfg_data[12:0];
        ibpg_pkg::CFG_ILEAVE_W:    ileave_w_r    <= cfg_data[4:0];
        ibpg_pkg::CFG_ILEAVE_H:    ileave_h_r    <= cfg_data[4:0];
      endcase
    end
  end

  // zero sizes count as one
  logic [4:0]  iw_eff;
  logic [4:0]  ih_eff;
  logic [12:0] pw_eff;
  logic [24:0] recip_w;
  logic [24:0] recip_h;

  assign iw_eff  = (ileave_w_r == 5'd0) ? 5'd1 : ileave_w_r;
  assign ih_eff  = (ileave_h_r == 5'd0) ? 5'd1 : ileave_h_r;
  assign pw_eff  = (proj_width_r == 13'd0) ? 13'd1 : proj_width_r;
  assign recip_w = ibpg_pkg::recip(iw_eff);
  assign recip_h = ibpg_pkg::recip(ih_eff);

  // stage registers
  logic        s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_valid_r;
  logic [1:0]  s1_op_r, s2_op_r, s3_op_r;
  logic [11:0] s1_cell_r, s2_cell_r, s3_cell_r;
  logic [31:0] s1_word_r, s2_word_r, s3_word_r;
  logic        s1_mask_r, s2_mask_r, s3_mask_r, s4_mask_r;
  logic [11:0] s1_x_r, s2_x_r;
  logic [11:0] s1_y_r;
  logic [8:0]  s1_off_r;
  logic [11:0] s1_qx_r, s2_qx_r, s3_qx_r;
  logic [11:0] s1_qy_r, s2_qy_r;
  logic [12:0] s1_qc_r, s2_cols_r, s2_colsw_r;
  logic [8:0]  s1_qo_r, s2_oy_r;
  logic [4:0]  s2_rx_r, s2_ry_r, s2_ro_r;
  logic [24:0] s3_prod_r;
  logic        s3_active_r, s4_active_r;
  logic        s3_use_data_r, s4_use_data_r;
  logic [5:0]  s3_bitpos_r, s4_bitpos_r;
  logic        s3_bit_ok_r, s4_bit_ok_r;
  logic        s4_in_range_r;
  ibpg_pkg::out_item_t out_data_r;

  // per stage load enables, a stage takes new contents when empty or draining
  logic en_o, en4, en3, en2, en1;
  assign en_o     = !out_valid_r || out_ready;
  assign en4      = !s4_v_r || en_o;
  assign en3      = !s3_v_r || en4;
  assign en2      = !s2_v_r || en3;
  assign en1      = !s1_v_r || en2;
  assign in_ready = en1;

  // stage 1: quotients by reciprocal multiply
  logic        in_xfer;
  logic        s1_v_nxt;
  logic [8:0]  off_nxt;
  logic [12:0] qx_nxt, qy_nxt, qc_nxt, qo_nxt;

  assign in_xfer  = in_valid && in_ready;
  assign s1_v_nxt = in_xfer && (in_data.op != ibpg_pkg::OP_RSVD);
  assign off_nxt  = mode_r ? (cal_frame_r - 9'd1) : {1'b0, ileave_idx_r};
  assign qx_nxt   = ibpg_pkg::div_q({1'b0, in_data.pixel_x}, recip_w);
  assign qy_nxt   = ibpg_pkg::div_q({1'b0, in_data.pixel_y}, recip_h);
  assign qc_nxt   = ibpg_pkg::div_q(pw_eff, recip_w);
  assign qo_nxt   = ibpg_pkg::div_q({4'b0, off_nxt}, recip_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_op_r   <= in_data.op;
      s1_cell_r <= in_data.cell_index;
      s1_word_r <= in_data.cell_word;
      s1_mask_r <= in_data.mask_bit;
      s1_x_r    <= in_data.pixel_x;
      s1_y_r    <= in_data.pixel_y;
      s1_off_r  <= off_nxt;
      s1_qx_r   <= qx_nxt[11:0];
      s1_qy_r   <= qy_nxt[11:0];
      s1_qc_r   <= qc_nxt;
      s1_qo_r   <= qo_nxt[8:0];
    end
  end

  // stage 2: remainders and whole-cell width
  logic [16:0] px, py, po;
  logic [17:0] pc;
  logic [11:0] rx_full, ry_full;
  logic [8:0]  ro_full;

  assign px      = 17'(s1_qx_r) * 17'(iw_eff);
  assign py      = 17'(s1_qy_r) * 17'(ih_eff);
  assign po      = 17'(s1_qo_r) * 17'(iw_eff);
  assign pc      = 18'(s1_qc_r) * 18'(iw_eff);
  assign rx_full = s1_x_r - px[11:0];
  assign ry_full = s1_y_r - py[11:0];
  assign ro_full = s1_off_r - po[8:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_op_r    <= s1_op_r;
      s2_cell_r  <= s1_cell_r;
      s2_word_r  <= s1_word_r;
      s2_mask_r  <= s1_mask_r;
      s2_x_r     <= s1_x_r;
      s2_qx_r    <= s1_qx_r;
      s2_qy_r    <= s1_qy_r;
      s2_cols_r  <= s1_qc_r;
      s2_colsw_r <= pc[12:0];
      s2_rx_r    <= rx_full[4:0];
      s2_ry_r    <= ry_full[4:0];
      s2_ro_r    <= ro_full[4:0];
      s2_oy_r    <= s1_qo_r;
    end
  end

  // stage 3: active offset test, row product, bit selection
  logic        hit_off, scan_in, cal_in, active_nxt;
  logic [24:0] prod_nxt;
  logic        use_data_nxt;
  logic [5:0]  par_pos;
  logic [5:0]  bitpos_nxt;
  logic        bit_ok_nxt;

  assign hit_off    = (s2_rx_r == s2_ro_r) && ({4'b0, s2_ry_r} == s2_oy_r)
                      && (s2_oy_r < {4'b0, ih_eff});
  assign scan_in    = {1'b0, s2_x_r} < s2_colsw_r;
  assign cal_in     = ({1'b0, s2_x_r} < pw_eff) && (cal_frame_r != 9'd0);
  assign active_nxt = hit_off && (mode_r ? cal_in : scan_in);
  assign prod_nxt   = 25'(s2_qy_r) * 25'(s2_cols_r);

  assign use_data_nxt = scan_frame_r < data_frames_r;
  assign par_pos      = scan_frame_r - data_frames_r;
  assign bitpos_nxt   = use_data_nxt ? scan_frame_r : par_pos;
  assign bit_ok_nxt   = use_data_nxt ? ({1'b0, scan_frame_r} < 7'(DATA_BITS))
                                     : ({1'b0, par_pos} < 7'(PARITY_BITS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_op_r       <= s2_op_r;
      s3_cell_r     <= s2_cell_r;
      s3_word_r     <= s2_word_r;
      s3_mask_r     <= s2_mask_r;
      s3_qx_r       <= s2_qx_r;
      s3_prod_r     <= prod_nxt;
      s3_active_r   <= active_nxt;
      s3_use_data_r <= use_data_nxt;
      s3_bitpos_r   <= bitpos_nxt;
      s3_bit_ok_r   <= bit_ok_nxt;
    end
  end

  // cell number, memory access; a load writes as it leaves stage 3
  logic [ibpg_pkg::CNUM_W-1:0] cnum;
  logic [ibpg_pkg::CNUM_W-1:0] cell_ext;
  logic [ibpg_pkg::CNUM_W-1:0] mem_idx;
  logic                        idx_in_range;
  logic                        s3_render;
  logic                        mem_we_data, mem_we_par, mem_re;
  logic [DATA_BITS-1:0]        mem_rd_data;
  logic [PARITY_BITS-1:0]      mem_rd_par;

  assign s3_render    = s3_op_r == ibpg_pkg::OP_RENDER;
  assign cnum         = ibpg_pkg::CNUM_W'(s3_qx_r) + ibpg_pkg::CNUM_W'(s3_prod_r);
  assign cell_ext     = ibpg_pkg::CNUM_W'(s3_cell_r);
  assign mem_idx      = s3_render ? cnum : cell_ext;
  assign idx_in_range = mem_idx < ibpg_pkg::CNUM_W'(MAX_CELLS);
  assign mem_re       = en4 && s3_v_r && s3_render && idx_in_range;
  assign mem_we_data  = en4 && s3_v_r && (s3_op_r == ibpg_pkg::OP_LOAD_DATA)
                        && idx_in_range;
  assign mem_we_par   = en4 && s3_v_r && (s3_op_r == ibpg_pkg::OP_LOAD_PARITY)
                        && idx_in_range;

  ibpg_cell_mem #(
    .DEPTH  (MAX_CELLS),
    .DATA_W (DATA_BITS),
    .PAR_W  (PARITY_BITS)
  ) u_cell_mem (
    .clk     (clk),
    .we_data (mem_we_data),
    .we_par  (mem_we_par),
    .re      (mem_re),
    .addr    (mem_idx[CELL_AW-1:0]),
    .wdata   (s3_word_r[DATA_BITS-1:0]),
    .wpar    (s3_word_r[PARITY_BITS-1:0]),
    .rd_data (mem_rd_data),
    .rd_par  (mem_rd_par)
  );

  // stage 4: renders only, alongside the memory read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en4) begin
      s4_v_r <= s3_v_r && s3_render;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_mask_r     <= s3_mask_r;
      s4_active_r   <= s3_active_r;
      s4_in_range_r <= idx_in_range;
      s4_use_data_r <= s3_use_data_r;
      s4_bitpos_r   <= s3_bitpos_r;
      s4_bit_ok_r   <= s3_bit_ok_r;
    end
  end

  // bit pick and light gating
  logic [DATA_BITS-1:0]   data_sh;
  logic [PARITY_BITS-1:0] par_sh;
  logic                   word_bit, lit;
  ibpg_pkg::out_item_t    out_nxt;

  assign data_sh  = mem_rd_data >> s4_bitpos_r;
  assign par_sh   = mem_rd_par >> s4_bitpos_r;
  assign word_bit = s4_use_data_r ? data_sh[0] : par_sh[0];
  assign lit      = mode_r ? s4_active_r
                           : (s4_active_r && s4_in_range_r && s4_bit_ok_r && word_bit);

  always_comb begin
    out_nxt.luminance        = (lit && s4_mask_r) ? ibpg_pkg::LUM_ON : ibpg_pkg::LUM_OFF;
    out_nxt.in_active_offset = s4_active_r;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_o) begin
      out_valid_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // the memory port serves a write or a read, never both
  assert property (@(posedge clk) disable iff (!rst_n)
    !((mem_we_data || mem_we_par) && mem_re))
    else $error("cell memory write and read in the same cycle");

  // input only stalls behind a held result
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  // light only at the active offset
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.luminance == ibpg_pkg::LUM_OFF
                   || (out_data.luminance == ibpg_pkg::LUM_ON && out_data.in_active_offset)))
    else $error("lit pixel outside the active offset");

  // a render leaving stage 3 with a valid cell number was read from memory
  assert property (@(posedge clk) disable iff (!rst_n)
    (en4 && s3_v_r && s3_render) |=> (s4_v_r && (s4_in_range_r == $past(mem_re))))
    else $error("render lost its memory read");
`endif

endmodule
